FILE: rtl/core/swv_pkg.sv
// Shared widths, command codes, drive kinds and register indexes for the
// swerve module target optimizer. No dependencies.
`default_nettype none
package swv_pkg;

  localparam int CMD_W     = 3;
  localparam int VAL_W     = 16;
  localparam int KIND_W    = 2;
  localparam int LIM_W     = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_SPEED = 3'd0,
    CMD_SET_FORCE = 3'd1,
    CMD_SET_BOTH  = 3'd2,
    CMD_TICK      = 3'd3,
    CMD_STOP      = 3'd4
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SPEED   = 2'd0,
    KIND_CURRENT = 2'd1,
    KIND_STOP    = 2'd2
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_DEADBAND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_DEADBAND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT  = 3'd5;

  localparam logic [VAL_W-1:0] FORCE_GAIN_RESET = 16'd256;

endpackage
`default_nettype wire

FILE: rtl/core/swv_in_if.sv
// Command channel of the swerve module target optimizer.
// Depends on swv_pkg.
`default_nettype none
interface swv_in_if
  import swv_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [VAL_W-1:0] speed_in;
  logic signed [VAL_W-1:0] force_in;
  logic signed [VAL_W-1:0] angle_in;
  logic signed [VAL_W-1:0] measured_angle;

  modport source (output valid, cmd, speed_in, force_in, angle_in, measured_angle,
                  input ready);
  modport sink (input valid, cmd, speed_in, force_in, angle_in, measured_angle,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/core/swv_out_if.sv
// Result channel of the swerve module target optimizer.
// Depends on swv_pkg.
`default_nettype none
interface swv_out_if
  import swv_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] steer_target;
  logic [KIND_W-1:0]       drive_kind;
  logic signed [VAL_W-1:0] speed_target;
  logic signed [VAL_W-1:0] current_target;
  logic                    flipped;

  modport source (output valid, steer_target, drive_kind, speed_target, current_target,
                  flipped, input ready);
  modport sink (input valid, steer_target, drive_kind, speed_target, current_target,
                flipped, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/swerve_module_target_optimizer.sv
// Swerve module target optimizer: target state, flip logic and current scaling.
// Depends on swv_pkg, swv_in_if and swv_out_if.
//
//   channel   direction  handshake          contents
//   in_ch     sink       valid/ready        cmd, speed_in, force_in, angle_in,
//                                           measured_angle
//   out_ch    source     valid/ready        steer_target, drive_kind,
//                                           speed_target, current_target, flipped
//   cfg_*     write      cfg_we             cfg_idx, cfg_data
//
// The state update and the gain multiply settle in the accept cycle and land in
// the result register on the same edge.
// One item per cycle is sustained while out_ch.ready stays high.
// A result waiting in the register holds in_ch.ready low until it is taken.
// Reset returns the target state, config registers and result valid flag to their defaults.
`default_nettype none
module swerve_module_target_optimizer
  import swv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  swv_in_if.sink                    in_ch,
  swv_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  logic [VAL_W-1:0] force_gain_r;
  logic [LIM_W-1:0] speed_deadband_r;
  logic [LIM_W-1:0] force_deadband_r;
  logic [LIM_W-1:0] speed_limit_r;
  logic [LIM_W-1:0] force_limit_r;
  logic [LIM_W-1:0] current_limit_r;

  logic signed [VAL_W-1:0] angle_r, angle_nxt;
  logic signed [VAL_W-1:0] speed_r, speed_nxt;
  logic signed [VAL_W-1:0] force_r, force_nxt;
  logic signed [VAL_W-1:0] current_r, current_nxt;
  logic [1:0]              mode_r, mode_nxt;

  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_steer_r;
  logic [KIND_W-1:0]       out_kind_r, out_kind_nxt;
  logic signed [VAL_W-1:0] out_speed_r;
  logic signed [VAL_W-1:0] out_current_r;
  logic                    out_flipped_r, flip_nxt;

  logic in_acc;

  function automatic logic signed [VAL_W-1:0] clamp_mag(
    input logic signed [VAL_W-1:0] v,
    input logic [LIM_W-1:0]        lim
  );
    logic signed [VAL_W:0]   l;
    logic signed [VAL_W:0]   nl;
    logic signed [VAL_W:0]   vx;
    logic signed [VAL_W-1:0] res;
    l   = $signed({2'b00, lim});
    nl  = -l;
    vx  = $signed({v[VAL_W-1], v});
    res = v;
    if (lim != '0) begin
      if (vx > l) begin
        res = l[VAL_W-1:0];
      end else if (vx < nl) begin
        res = nl[VAL_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic logic signed [VAL_W-1:0] neg_sat(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] res;
    if (v == {1'b1, {(VAL_W-1){1'b0}}}) begin
      res = {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      res = -v;
    end
    return res;
  endfunction

  function automatic logic [VAL_W-1:0] mag(input logic signed [VAL_W-1:0] v);
    return v[VAL_W-1] ? (~v + 1'b1) : v;
  endfunction

  // Tick path: deadband test, flip test, then scaled and limited current; also the clamped set inputs.
  logic                    dead;
  logic signed [VAL_W-1:0] err;
  logic                    do_flip;
  logic signed [VAL_W-1:0] tick_speed, tick_force, tick_angle;
  logic [VAL_W-1:0]        force_mag;
  logic [2*VAL_W-1:0]      prod;
  logic [2*VAL_W:0]        prod_rnd;
  logic [2*VAL_W-8:0]      cur_mag_raw;
  logic [VAL_W-1:0]        lim_sel;
  logic [VAL_W-1:0]        cur_mag;
  logic signed [VAL_W-1:0] tick_current;
  logic signed [VAL_W-1:0] spd_clamped, frc_clamped;

  always_comb begin
    dead = ({1'b0, mag(speed_r)} < {2'b00, speed_deadband_r}) &&
           ({1'b0, mag(force_r)} < {2'b00, force_deadband_r});
    err = angle_r - in_ch.measured_angle;
    do_flip = !dead && ((err > 16'sd16384) || (err < -16'sd16384));
    tick_angle = angle_r;
    tick_speed = speed_r;
    tick_force = force_r;
    if (dead) begin
      tick_speed = '0;
      tick_force = '0;
    end else if (do_flip) begin
      tick_angle = angle_r ^ {1'b1, {(VAL_W-1){1'b0}}};
      tick_speed = neg_sat(speed_r);
      tick_force = neg_sat(force_r);
    end
    force_mag   = mag(tick_force);
    prod        = force_mag * force_gain_r;
    prod_rnd    = {1'b0, prod} + (2*VAL_W+1)'(128);
    cur_mag_raw = prod_rnd[2*VAL_W:8];
    if (current_limit_r != '0) begin
      lim_sel = {1'b0, current_limit_r};
    end else if (tick_force[VAL_W-1]) begin
      lim_sel = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      lim_sel = {1'b0, {(VAL_W-1){1'b1}}};
    end
    cur_mag = (cur_mag_raw > {{(VAL_W-7){1'b0}}, lim_sel}) ? lim_sel
                                                           : cur_mag_raw[VAL_W-1:0];
    tick_current = tick_force[VAL_W-1] ? $signed(~cur_mag + 1'b1) : $signed(cur_mag);
    spd_clamped  = clamp_mag(in_ch.speed_in, speed_limit_r);
    frc_clamped  = clamp_mag(in_ch.force_in, force_limit_r);
  end

  always_comb begin
    angle_nxt   = angle_r;
    speed_nxt   = speed_r;
    force_nxt   = force_r;
    current_nxt = current_r;
    mode_nxt    = mode_r;
    flip_nxt    = 1'b0;
    case (cmd_t'(in_ch.cmd))
      CMD_SET_SPEED, CMD_SET_FORCE, CMD_SET_BOTH: begin
        mode_nxt    = in_ch.cmd[1:0];
        speed_nxt   = (in_ch.cmd == CMD_SET_FORCE) ? '0 : spd_clamped;
        force_nxt   = (in_ch.cmd == CMD_SET_SPEED) ? '0 : frc_clamped;
        current_nxt = '0;
        angle_nxt   = in_ch.angle_in;
      end
      CMD_TICK: begin
        angle_nxt   = tick_angle;
        speed_nxt   = tick_speed;
        force_nxt   = tick_force;
        current_nxt = tick_current;
        flip_nxt    = do_flip;
      end
      CMD_STOP: begin
        speed_nxt   = '0;
        force_nxt   = '0;
        current_nxt = '0;
      end
      default: begin
      end
    endcase
    if (in_ch.cmd == CMD_STOP) begin
      out_kind_nxt = KIND_STOP;
    end else if (mode_nxt == 2'd0) begin
      out_kind_nxt = KIND_SPEED;
    end else begin
      out_kind_nxt = KIND_CURRENT;
    end
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_gain_r     <= FORCE_GAIN_RESET;
      speed_deadband_r <= '0;
      force_deadband_r <= '0;
      speed_limit_r    <= '0;
      force_limit_r    <= '0;
      current_limit_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_FORCE_GAIN:     force_gain_r     <= cfg_data;
        CFG_SPEED_DEADBAND: speed_deadband_r <= cfg_data[LIM_W-1:0];
        CFG_FORCE_DEADBAND: force_deadband_r <= cfg_data[LIM_W-1:0];
        CFG_SPEED_LIMIT:    speed_limit_r    <= cfg_data[LIM_W-1:0];
        CFG_FORCE_LIMIT:    force_limit_r    <= cfg_data[LIM_W-1:0];
        CFG_CURRENT_LIMIT:  current_limit_r  <= cfg_data[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r     <= '0;
      speed_r     <= '0;
      force_r     <= '0;
      current_r   <= '0;
      mode_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        angle_r     <= angle_nxt;
        speed_r     <= speed_nxt;
        force_r     <= force_nxt;
        current_r   <= current_nxt;
        mode_r      <= mode_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_steer_r   <= angle_nxt;
      out_kind_r    <= out_kind_nxt;
      out_speed_r   <= speed_nxt;
      out_current_r <= current_nxt;
      out_flipped_r <= flip_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.steer_target   = out_steer_r;
  assign out_ch.drive_kind     = out_kind_r;
  assign out_ch.speed_target   = out_speed_r;
  assign out_ch.current_target = out_current_r;
  assign out_ch.flipped        = out_flipped_r;

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.cmd == CMD_STOP) |=>
      out_valid_r && (out_kind_r == KIND_STOP) && (out_speed_r == '0) &&
      (out_current_r == '0))
    else $error("stop item did not clear the drive targets");

  a_flip_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.cmd != CMD_TICK) |=> !out_flipped_r)
    else $error("flip reported for an item that is not a tick");

  a_set_angle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ((in_ch.cmd == CMD_SET_SPEED) || (in_ch.cmd == CMD_SET_FORCE) ||
               (in_ch.cmd == CMD_SET_BOTH)) |=>
      (out_steer_r == $past(in_ch.angle_in)) && (out_current_r == '0))
    else $error("set item did not load the requested angle");

endmodule
`default_nettype wire
